[rtl/prd_pkg.sv]
// prd_pkg: shared constants, cordic angle table and register codes
// for the phase residue detector; no dependencies
`default_nettype none

package prd_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int CHARGE_W     = 3;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    localparam logic REG_NUM_COLS = 1'b0;
    localparam logic REG_NUM_ROWS = 1'b1;

    // atan(2^-i) in units of 2^-16 turn
    localparam logic [15:0] ATAN_TURNS16 [CORDIC_STEPS] = '{
        16'd8192, 16'd4836, 16'd2555, 16'd1297, 16'd651, 16'd326, 16'd163, 16'd81,
        16'd41,   16'd20,   16'd10,   16'd5,    16'd3,   16'd1,   16'd1,   16'd0
    };

    function automatic logic [31:0] atan_step(input logic [STEP_W-1:0] step, input int pbits);
        logic [31:0] base;
        base = 32'(ATAN_TURNS16[step]);
        if (pbits >= 16) begin
            return base << (pbits - 16);
        end
        return base >> (16 - pbits);
    endfunction

endpackage

`default_nettype wire

[rtl/prd_cordic.sv]
// prd_cordic: pipelined vectoring cordic, one stage per step, sample to phase in turns
// depends on prd_pkg for the angle table
`default_nettype none

module prd_cordic #(
    parameter int SAMPLE_BITS = 16,
    parameter int PHASE_BITS  = 16,
    parameter int TAG_BITS    = 1
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire logic signed [SAMPLE_BITS-1:0] i_re,
    input  wire logic signed [SAMPLE_BITS-1:0] i_im,
    input  wire logic [TAG_BITS-1:0]           i_tag,
    output logic                               o_valid,
    output logic [PHASE_BITS-1:0]              o_phase,
    output logic [TAG_BITS-1:0]                o_tag
);
    import prd_pkg::*;

    // scaled by 256, plus headroom for the half-turn flip and cordic gain
    localparam int XW = SAMPLE_BITS + 11;

    logic signed [XW-1:0]   x0, y0, n_x0, n_y0;
    logic [PHASE_BITS-1:0]  n_a0;
    logic signed [XW-1:0]   r_x   [CORDIC_STEPS];
    logic signed [XW-1:0]   r_y   [CORDIC_STEPS];
    logic [PHASE_BITS-1:0]  r_a   [CORDIC_STEPS+1];
    logic [TAG_BITS-1:0]    r_tag [CORDIC_STEPS+1];
    logic                   r_v   [CORDIC_STEPS+1];

    always_comb begin
        x0 = {{3{i_re[SAMPLE_BITS-1]}}, i_re, 8'd0};
        y0 = {{3{i_im[SAMPLE_BITS-1]}}, i_im, 8'd0};
        if (i_re[SAMPLE_BITS-1]) begin
            n_x0 = -x0;
            n_y0 = -y0;
            n_a0 = {1'b1, {(PHASE_BITS-1){1'b0}}};
        end else begin
            n_x0 = x0;
            n_y0 = y0;
            n_a0 = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]   <= n_x0;
            r_y[0]   <= n_y0;
            r_a[0]   <= n_a0;
            r_tag[0] <= i_tag;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        localparam logic [31:0] ANG = atan_step(STEP_W'(i), PHASE_BITS);
        logic                 y_pos;

        assign y_pos = !r_y[i][XW-1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (i_en) begin
                r_v[i+1] <= r_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tag[i+1] <= r_tag[i];
                r_a[i+1]   <= y_pos ? r_a[i] + ANG[PHASE_BITS-1:0]
                                    : r_a[i] - ANG[PHASE_BITS-1:0];
            end
        end

        if (i < CORDIC_STEPS - 1) begin : g_xy
            logic signed [XW-1:0] xs, ys;

            assign xs = r_x[i] >>> i;
            assign ys = r_y[i] >>> i;

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x[i+1] <= y_pos ? r_x[i] + ys : r_x[i] - ys;
                    r_y[i+1] <= y_pos ? r_y[i] - xs : r_y[i] + xs;
                end
            end
        end
    end

    assign o_valid = r_v[CORDIC_STEPS];
    assign o_phase = r_a[CORDIC_STEPS];
    assign o_tag   = r_tag[CORDIC_STEPS];

endmodule

`default_nettype wire

[rtl/prd_residue.sv]
// prd_residue: line buffer of the previous row's phases, 2x2 cell winding number
// depends on prd_pkg; fed by prd_cordic
`default_nettype none

module prd_residue #(
    parameter int PHASE_BITS = 16,
    parameter int DEPTH      = 1024,
    parameter int TAG_BITS   = 1
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_en,
    input  wire logic                            i_valid,
    input  wire logic [$clog2(DEPTH)-1:0]        i_col,
    input  wire logic [PHASE_BITS-1:0]           i_phase,
    input  wire logic                            i_nz,
    input  wire logic [TAG_BITS-1:0]             i_tag,
    output logic                                 o_valid,
    output logic signed [prd_pkg::CHARGE_W-1:0] o_charge,
    output logic [TAG_BITS-1:0]                  o_tag
);
    import prd_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int EW = PHASE_BITS + 1;
    localparam int SW = PHASE_BITS + 2;

    logic [EW-1:0] mem [DEPTH];

    logic                   r_valid;
    logic [EW-1:0]          r_above, r_cur, r_left, r_ul;
    logic [AW-1:0]          r_col;
    logic [TAG_BITS-1:0]    r_tag, r_out_tag;
    logic                   r_out_valid;
    logic signed [CHARGE_W-1:0] r_charge, n_charge;

    logic signed [PHASE_BITS-1:0] d_ba, d_cb, d_dc, d_ad;
    logic signed [SW-1:0]         sum;
    logic                         all_nz;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_above <= mem[i_col];
        end
        if (i_en && r_valid) begin
            mem[r_col] <= r_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_out_valid <= 1'b0;
            r_left      <= '0;
            r_ul        <= '0;
        end else if (i_en) begin
            r_valid     <= i_valid;
            r_out_valid <= r_valid;
            if (r_valid) begin
                r_left <= r_cur;
                r_ul   <= r_above;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cur     <= {i_nz, i_phase};
            r_col     <= i_col;
            r_tag     <= i_tag;
            r_charge  <= n_charge;
            r_out_tag <= r_tag;
        end
    end

    // loop upper-left -> left -> current -> above -> upper-left
    always_comb begin
        d_ba   = r_left[PHASE_BITS-1:0]  - r_ul[PHASE_BITS-1:0];
        d_cb   = r_cur[PHASE_BITS-1:0]   - r_left[PHASE_BITS-1:0];
        d_dc   = r_above[PHASE_BITS-1:0] - r_cur[PHASE_BITS-1:0];
        d_ad   = r_ul[PHASE_BITS-1:0]    - r_above[PHASE_BITS-1:0];
        sum    = SW'(d_ba) + SW'(d_cb) + SW'(d_dc) + SW'(d_ad);
        all_nz = r_ul[PHASE_BITS] & r_left[PHASE_BITS] & r_cur[PHASE_BITS]
                 & r_above[PHASE_BITS];
        if (all_nz) begin
            n_charge = {sum[SW-1], sum[SW-1:PHASE_BITS]};
        end else begin
            n_charge = '0;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_charge = r_charge;
    assign o_tag    = r_out_tag;

endmodule

`default_nettype wire

[rtl/phase_residue_detector.sv]
// phase_residue_detector: top level with config registers, raster counters and result word
// throughput: one word per cycle, unless held as below, through the cordic and the line buffer stages
// the whole pipeline holds while a result word waits for i_out_ready
// reset: counters, tally and valid bits clear; line buffer contents are not cleared
// depends on prd_pkg, prd_cordic, prd_residue
`default_nettype none

module phase_residue_detector #(
    parameter int MAX_COLS    = 1024,
    parameter int MAX_ROWS    = 4096,
    parameter int SAMPLE_BITS = 16,
    parameter int PHASE_BITS  = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [prd_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [prd_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [prd_pkg::APB_DATA_W-1:0]          prdata,
    output logic                                    pready,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]      i_sample_re,
    input  wire logic signed [SAMPLE_BITS-1:0]      i_sample_im,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [$clog2(MAX_ROWS)-1:0]             o_cell_row,
    output logic [$clog2(MAX_COLS)-1:0]             o_cell_col,
    output logic signed [prd_pkg::CHARGE_W-1:0]     o_charge,
    output logic [$clog2((MAX_ROWS-1)*(MAX_COLS-1)+1)-1:0] o_vortex_total,
    output logic                                    o_last_cell
);
    import prd_pkg::*;

    localparam int CW   = $clog2(MAX_COLS);
    localparam int RW   = $clog2(MAX_ROWS);
    localparam int NC_W = $clog2(MAX_COLS + 1);
    localparam int NR_W = $clog2(MAX_ROWS + 1);
    localparam int TW   = $clog2((MAX_ROWS-1)*(MAX_COLS-1) + 1);

    localparam int COL_LO   = 0;
    localparam int ROW_LO   = CW;
    localparam int ACT_BIT  = CW + RW;
    localparam int LAST_BIT = CW + RW + 1;
    localparam int NZ_BIT   = CW + RW + 2;
    localparam int TAG_BITS = CW + RW + 3;

    logic [NC_W-1:0] r_num_cols;
    logic [NR_W-1:0] r_num_rows;
    logic            cfg_wr;

    logic [CW:0]     cols_eff, col_nx;
    logic [RW:0]     rows_eff, row_nx;
    logic [CW-1:0]   r_col;
    logic [RW-1:0]   r_row;
    logic            pipe_en, accept, col_wrap, row_wrap, nz;
    logic [TAG_BITS-1:0] in_tag, cor_tag, res_tag;

    logic                  cor_valid, res_valid;
    logic [PHASE_BITS-1:0] cor_phase;
    logic signed [CHARGE_W-1:0] res_charge;

    logic            r_out_valid;
    logic [RW-1:0]   r_cell_row;
    logic [CW-1:0]   r_cell_col;
    logic signed [CHARGE_W-1:0] r_charge;
    logic [TW-1:0]   r_tally, n_tally, r_total;
    logic            r_last;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_cols <= NC_W'(MAX_COLS);
            r_num_rows <= NR_W'(MAX_ROWS);
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_NUM_COLS: r_num_cols <= pwdata[NC_W-1:0];
                REG_NUM_ROWS: r_num_rows <= pwdata[NR_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_NUM_COLS: prdata = APB_DATA_W'(r_num_cols);
            REG_NUM_ROWS: prdata = APB_DATA_W'(r_num_rows);
        endcase
    end

    always_comb begin
        if (r_num_cols < NC_W'(2)) begin
            cols_eff = (CW+1)'(2);
        end else if (r_num_cols > NC_W'(MAX_COLS)) begin
            cols_eff = (CW+1)'(MAX_COLS);
        end else begin
            cols_eff = (CW+1)'(r_num_cols);
        end
        if (r_num_rows < NR_W'(2)) begin
            rows_eff = (RW+1)'(2);
        end else if (r_num_rows > NR_W'(MAX_ROWS)) begin
            rows_eff = (RW+1)'(MAX_ROWS);
        end else begin
            rows_eff = (RW+1)'(r_num_rows);
        end
    end

    // raster position of the incoming word
    assign pipe_en    = !r_out_valid || i_out_ready;
    assign o_in_ready = pipe_en;
    assign accept     = i_in_valid && pipe_en;

    always_comb begin
        col_nx   = {1'b0, r_col} + (CW+1)'(1);
        row_nx   = {1'b0, r_row} + (RW+1)'(1);
        col_wrap = col_nx >= cols_eff;
        row_wrap = row_nx >= rows_eff;
        nz       = (i_sample_re != '0) || (i_sample_im != '0);
        in_tag   = '0;
        in_tag[COL_LO +: CW] = r_col;
        in_tag[ROW_LO +: RW] = r_row;
        in_tag[ACT_BIT]      = (r_row != '0) && (r_col != '0);
        in_tag[LAST_BIT]     = col_wrap && row_wrap;
        in_tag[NZ_BIT]       = nz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (col_wrap) begin
                r_col <= '0;
                r_row <= row_wrap ? '0 : row_nx[RW-1:0];
            end else begin
                r_col <= col_nx[CW-1:0];
            end
        end
    end

    prd_cordic #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .PHASE_BITS  (PHASE_BITS),
        .TAG_BITS    (TAG_BITS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (i_in_valid),
        .i_re    (i_sample_re),
        .i_im    (i_sample_im),
        .i_tag   (in_tag),
        .o_valid (cor_valid),
        .o_phase (cor_phase),
        .o_tag   (cor_tag)
    );

    prd_residue #(
        .PHASE_BITS (PHASE_BITS),
        .DEPTH      (MAX_COLS),
        .TAG_BITS   (TAG_BITS)
    ) u_residue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (pipe_en),
        .i_valid  (cor_valid),
        .i_col    (cor_tag[COL_LO +: CW]),
        .i_phase  (cor_phase),
        .i_nz     (cor_tag[NZ_BIT]),
        .i_tag    (cor_tag),
        .o_valid  (res_valid),
        .o_charge (res_charge),
        .o_tag    (res_tag)
    );

    // result word and running tally
    always_comb begin
        n_tally = r_tally + ((res_charge != '0) ? TW'(1) : TW'(0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_tally     <= '0;
        end else if (pipe_en) begin
            r_out_valid <= res_valid && res_tag[ACT_BIT];
            if (res_valid) begin
                if (res_tag[LAST_BIT]) begin
                    r_tally <= '0;
                end else if (res_tag[ACT_BIT]) begin
                    r_tally <= n_tally;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_cell_row <= res_tag[ROW_LO +: RW] - RW'(1);
            r_cell_col <= res_tag[COL_LO +: CW] - CW'(1);
            r_charge   <= res_charge;
            r_total    <= n_tally;
            r_last     <= res_tag[LAST_BIT];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_cell_row     = r_cell_row;
    assign o_cell_col     = r_cell_col;
    assign o_charge       = r_charge;
    assign o_vortex_total = r_total;
    assign o_last_cell    = r_last;

    a_charge_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_charge == 3'sd0 || o_charge == 3'sd1
                         || o_charge == -3'sd1 || o_charge == -3'sd2))
        else $error("charge outside winding range");

    a_tally_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_charge != '0) |-> (o_vortex_total != '0))
        else $error("nonzero charge not counted");

    a_tally_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last_cell)
            |=> (!o_out_valid || o_vortex_total >= $past(o_vortex_total)))
        else $error("tally dropped inside a frame");

endmodule

`default_nettype wire

[tb/sv/phase_residue_detector_tb.sv]
// phase_residue_detector_tb: self-checking bench for the phase residue detector,
// streams raster frames of complex samples and checks each cell word against a cordic predictor
// depends on prd_pkg and phase_residue_detector
module phase_residue_detector_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import prd_pkg::*;

    localparam int COL_LIMIT     = 1024;
    localparam int ROW_LIMIT     = 4096;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 500000;

    localparam logic [APB_ADDR_W-1:0] ADDR_NUM_COLS = APB_ADDR_W'({REG_NUM_COLS, 2'b00});
    localparam logic [APB_ADDR_W-1:0] ADDR_NUM_ROWS = APB_ADDR_W'({REG_NUM_ROWS, 2'b00});

    typedef struct {
        logic [11:0] row;
        logic [9:0]  col;
        logic [2:0]  charge;
        logic [21:0] total;
        logic        last;
    } t_cell_word;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]        paddr = '0;
    logic [APB_DATA_W-1:0]        pwdata = '0;
    wire  [APB_DATA_W-1:0]        prdata;
    wire                          pready;
    logic                         i_in_valid = 1'b0;
    wire                          o_in_ready;
    logic signed [15:0]           i_sample_re = '0;
    logic signed [15:0]           i_sample_im = '0;
    wire                          o_out_valid;
    logic                         i_out_ready = 1'b0;
    wire  [11:0]                  o_cell_row;
    wire  [9:0]                   o_cell_col;
    wire  signed [CHARGE_W-1:0]   o_charge;
    wire  [21:0]                  o_vortex_total;
    wire                          o_last_cell;

    phase_residue_detector #(
        .MAX_COLS(COL_LIMIT),
        .MAX_ROWS(ROW_LIMIT),
        .SAMPLE_BITS(16),
        .PHASE_BITS(16)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_sample_re(i_sample_re),
        .i_sample_im(i_sample_im),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_cell_row(o_cell_row),
        .o_cell_col(o_cell_col),
        .o_charge(o_charge),
        .o_vortex_total(o_vortex_total),
        .o_last_cell(o_last_cell)
    );

    always #5 i_clk = ~i_clk;

    // atan(2^-i) in 2^-16 turn
    int atan_turns [16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                            41, 20, 10, 5, 3, 1, 1, 0};

    logic [10:0] cfg_cols = 11'd1024;
    logic [12:0] cfg_rows = 13'd4096;
    logic [16:0] line_phase [COL_LIMIT];
    logic [16:0] left_ph = '0;
    logic [16:0] upper_left_ph = '0;
    logic [11:0] row_cnt = '0;
    logic [9:0]  col_cnt = '0;
    logic [21:0] tally = '0;

    t_cell_word expected_cells [$];
    int errors = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int long_stall_cycles = 0;
    int stall_left = 0;

    function automatic int eff_cols();
        if (cfg_cols < 2) begin
            return 2;
        end
        if (cfg_cols > COL_LIMIT) begin
            return COL_LIMIT;
        end
        return int'(cfg_cols);
    endfunction

    function automatic int eff_rows();
        if (cfg_rows < 2) begin
            return 2;
        end
        if (cfg_rows > ROW_LIMIT) begin
            return ROW_LIMIT;
        end
        return int'(cfg_rows);
    endfunction

    function automatic logic [15:0] cordic_turns(input logic signed [15:0] re,
                                                 input logic signed [15:0] im);
        longint x, y, xs, ys, ang;
        int i;
        x = longint'(re) * 256;
        y = longint'(im) * 256;
        ang = 0;
        if (x < 0) begin
            x = -x;
            y = -y;
            ang = 32768;
        end
        for (i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                ang = ang + atan_turns[i];
            end else begin
                x = x - ys;
                y = y + xs;
                ang = ang - atan_turns[i];
            end
        end
        return ang[15:0];
    endfunction

    // half a turn counts as minus half a turn
    function automatic int wrapped_step(input logic [15:0] to_ph, input logic [15:0] from_ph);
        logic [15:0] d;
        d = to_ph - from_ph;
        if (d >= 16'd32768) begin
            return int'(d) - 65536;
        end
        return int'(d);
    endfunction

    function automatic void advance_raster(input logic signed [15:0] re,
                                           input logic signed [15:0] im);
        int cols, rows, loop_sum, winding;
        logic [16:0] cur, above;
        logic at_last;
        t_cell_word exp_word;
        cols = eff_cols();
        rows = eff_rows();
        cur = {(re != 0) || (im != 0), cordic_turns(re, im)};
        above = line_phase[col_cnt];
        at_last = (int'(row_cnt) >= rows - 1) && (int'(col_cnt) >= cols - 1);
        if (row_cnt != 0 && col_cnt != 0) begin
            winding = 0;
            if (upper_left_ph[16] && left_ph[16] && cur[16] && above[16]) begin
                loop_sum = wrapped_step(left_ph[15:0], upper_left_ph[15:0])
                         + wrapped_step(cur[15:0], left_ph[15:0])
                         + wrapped_step(above[15:0], cur[15:0])
                         + wrapped_step(upper_left_ph[15:0], above[15:0]);
                winding = loop_sum / 65536;
            end
            if (winding != 0) begin
                tally = tally + 1'b1;
            end
            exp_word.row = row_cnt - 1'b1;
            exp_word.col = col_cnt - 1'b1;
            exp_word.charge = winding[2:0];
            exp_word.total = tally;
            exp_word.last = at_last;
            expected_cells.push_back(exp_word);
        end
        upper_left_ph = above;
        left_ph = cur;
        line_phase[col_cnt] = cur;
        if (int'(col_cnt) + 1 >= cols) begin
            col_cnt = '0;
            if (int'(row_cnt) + 1 >= rows) begin
                row_cnt = '0;
                tally = '0;
            end else begin
                row_cnt = row_cnt + 1'b1;
            end
        end else begin
            col_cnt = col_cnt + 1'b1;
        end
    endfunction

    function automatic void match_field(input string label, input logic [21:0] want,
                                        input logic [21:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h got %0h", $time, label, want, got);
            errors++;
        end
    endfunction

    function automatic void check_cell();
        t_cell_word exp_word;
        if (expected_cells.size() == 0) begin
            $display("%0t: unexpected word, row %0d col %0d", $time, o_cell_row, o_cell_col);
            errors++;
        end else begin
            exp_word = expected_cells.pop_front();
            match_field("cell_row", 22'(exp_word.row), 22'(o_cell_row));
            match_field("cell_col", 22'(exp_word.col), 22'(o_cell_col));
            match_field("charge", 22'(exp_word.charge), 22'(unsigned'(o_charge)));
            match_field("vortex_total", exp_word.total, o_vortex_total);
            match_field("last_cell", 22'(exp_word.last), 22'(o_last_cell));
        end
    endfunction

    // result side: checker, random ready and the long hold-off
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            check_cell();
        end
        if (stall_left == 0 && long_stall_cycles > 0) begin
            stall_left = long_stall_cycles;
            long_stall_cycles = 0;
        end
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_NUM_COLS) begin
            cfg_cols = data[10:0];
        end else if (addr == ADDR_NUM_ROWS) begin
            cfg_rows = data[12:0];
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_sample(input logic signed [15:0] re, input logic signed [15:0] im);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample_re <= re;
        i_sample_im <= im;
        do @(posedge i_clk); while (!o_in_ready);
        advance_raster(re, im);
    endtask

    // sender pauses until every cell word is back, then lets the pipeline empty
    task automatic wait_for_idle();
        i_in_valid <= 1'b0;
        while (expected_cells.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [15:0] random_component();
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
            2, 3: return 16'($urandom_range(200)) - 16'd100;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_random_samples(input int count);
        int k;
        for (k = 0; k < count; k++) begin
            if ($urandom_range(19) == 0) begin
                send_sample(16'sd0, 16'sd0);
            end else begin
                send_sample(random_component(), random_component());
            end
        end
    endtask

    // negative vortices, half-turn pairs, zero corners and field extremes
    task automatic test_directed_cells();
        int dir_re [18];
        int dir_im [18];
        int k;
        dir_re = '{100, 0, -100, 0, -100, 0, 32767, -32768, 0,
                   1, -1, 32767, -1, 1, -32768, 0, 32767, -32768};
        dir_im = '{0, 100, 0, -100, 0, 100, 0, 0, 0,
                   0, 0, -32768, 0, 0, 32767, 0, 32767, -32768};
        wait_for_idle();
        write_reg(ADDR_NUM_COLS, 32'd3);
        write_reg(ADDR_NUM_ROWS, 32'd3);
        for (k = 0; k < 18; k++) begin
            send_sample(16'(dir_re[k]), 16'(dir_im[k]));
        end
    endtask

    task automatic test_register_clamp();
        wait_for_idle();
        write_reg(ADDR_NUM_COLS, 32'hFFFF_F801);
        write_reg(ADDR_NUM_ROWS, 32'd0);
        send_random_samples(8);
    endtask

    task automatic test_resize_mid_frame();
        wait_for_idle();
        write_reg(ADDR_NUM_COLS, 32'd6);
        write_reg(ADDR_NUM_ROWS, 32'd6);
        send_random_samples(15);
        wait_for_idle();
        write_reg(ADDR_NUM_COLS, 32'd3);
        send_random_samples(6);
        wait_for_idle();
        write_reg(ADDR_NUM_ROWS, 32'd2);
        send_random_samples(7);
    endtask

    task automatic test_random_frames(input int item_budget);
        int sent, cols_w, rows_w;
        sent = 0;
        while (sent < item_budget) begin
            wait_for_idle();
            case ($urandom_range(9))
                0: cols_w = $urandom_range(1);
                1: cols_w = $urandom_range(20, 12);
                default: cols_w = $urandom_range(8, 2);
            endcase
            rows_w = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(8, 2);
            write_reg(ADDR_NUM_COLS, {21'($urandom), 11'(cols_w)});
            write_reg(ADDR_NUM_ROWS, {19'($urandom), 13'(rows_w)});
            send_random_samples(eff_cols() * eff_rows());
            sent += eff_cols() * eff_rows();
        end
    endtask

    // result side holds off long enough to fill the pipeline and stall the input
    task automatic test_output_backpressure();
        wait_for_idle();
        write_reg(ADDR_NUM_COLS, 32'd4);
        write_reg(ADDR_NUM_ROWS, 32'd8);
        long_stall_cycles = 300;
        send_random_samples(64);
    endtask

    task automatic test_tall_frame();
        wait_for_idle();
        write_reg(ADDR_NUM_COLS, 32'd2);
        write_reg(ADDR_NUM_ROWS, 32'd4096);
        send_random_samples(40);
        wait_for_idle();
        write_reg(ADDR_NUM_ROWS, 32'h1FFF);
        send_random_samples(10);
        wait_for_idle();
        write_reg(ADDR_NUM_ROWS, 32'd1);
        send_random_samples(6);
    endtask

    task automatic test_wide_frame();
        wait_for_idle();
        write_reg(ADDR_NUM_COLS, 32'd1024);
        write_reg(ADDR_NUM_ROWS, 32'd2);
        send_random_samples(40);
        wait_for_idle();
        write_reg(ADDR_NUM_COLS, 32'h7FF);
        send_random_samples(10);
        wait_for_idle();
        write_reg(ADDR_NUM_COLS, 32'd2);
        send_random_samples(7);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 33;
        recv_idle_pct = 53;
        test_directed_cells();
        test_register_clamp();
        test_resize_mid_frame();
        test_random_frames(60);

        send_idle_pct = 53;
        recv_idle_pct = 33;
        test_random_frames(60);
        test_output_backpressure();
        test_tall_frame();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_frames(60);
        test_wide_frame();

        wait_for_idle();
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
